FILE: src/fwiv_pkg.sv
// Shared types, constants and the CRC byte step for the image validator.
package fwiv_pkg;

  localparam int COUNT_WIDTH_DEF = 17;
  localparam int SIZE_W          = 17;
  localparam int SIG_W           = 16;
  localparam int DATA_W          = 8;
  localparam int STATUS_W        = 2;
  localparam int CRC_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 17;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FILE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CRC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE = 2'd2;

  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
  localparam logic [SIZE_W-1:0] MIN_SIZE_RST  = 17'd1024;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST  = 17'd98304;
  localparam logic [SIG_W-1:0]  SIGNATURE_RST = 16'h4659;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic [SIZE_W-1:0] min_size;
    logic [SIZE_W-1:0] max_size;
    logic [SIG_W-1:0]  signature;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   image_bytes;
  } verdict_t;

  // CRC-16-CCITT, MSB first, one byte unrolled.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < DATA_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/fwiv_if.sv
// Valid/ready channel interfaces for image bytes and verdicts.
interface fwiv_byte_if;
  logic                         valid;
  logic                         ready;
  logic [fwiv_pkg::DATA_W-1:0]  data_byte;
  logic                         final_byte;

  modport source(output valid, data_byte, final_byte, input ready);
  modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface fwiv_verdict_if;
  logic                           valid;
  logic                           ready;
  logic [fwiv_pkg::STATUS_W-1:0]  status;
  logic [fwiv_pkg::SIZE_W-1:0]    image_bytes;

  modport source(output valid, status, image_bytes, input ready);
  modport sink(input valid, status, image_bytes, output ready);
endinterface

FILE: src/fwiv_image_state.sv
// Per-image state (count, CRC, footer) and the verdict logic for one beat.
module fwiv_image_state #(
  parameter int COUNT_WIDTH = fwiv_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  fwiv_pkg::beat_t    beat,
  input  fwiv_pkg::cfg_t     cfg,
  output fwiv_pkg::verdict_t verdict
);

  localparam int CMP_W = (COUNT_WIDTH > fwiv_pkg::SIZE_W) ? COUNT_WIDTH : fwiv_pkg::SIZE_W;

  logic [COUNT_WIDTH-1:0]      byte_total;
  logic [COUNT_WIDTH-1:0]      byte_total_next;
  logic [fwiv_pkg::CRC_W-1:0]  crc_value;
  logic [fwiv_pkg::CRC_W-1:0]  crc_value_next;
  // Only the three newest bytes are kept; the footer halfword is the
  // oldest two of them plus nothing of the incoming byte.
  logic [23:0]                 tail_bytes;
  logic [23:0]                 tail_bytes_next;
  logic [CMP_W-1:0]            size;
  logic [fwiv_pkg::SIG_W-1:0]  footer_sig;
  logic                        bad_file;

  always_comb begin
    byte_total_next = (&byte_total) ? byte_total : byte_total + 1'b1;
    crc_value_next  = fwiv_pkg::crc16_byte(crc_value, beat.data);
    tail_bytes_next = {tail_bytes[15:0], beat.data};
    size            = CMP_W'(byte_total_next);
    footer_sig      = tail_bytes[23:8];
    bad_file = (size < CMP_W'(cfg.min_size)) || (size > CMP_W'(cfg.max_size)) ||
               (size[1:0] != 2'b00) || (footer_sig != cfg.signature);
    if (bad_file) begin
      verdict.status = fwiv_pkg::STATUS_BAD_FILE;
    end else if (crc_value_next != '0) begin
      verdict.status = fwiv_pkg::STATUS_BAD_CRC;
    end else begin
      verdict.status = fwiv_pkg::STATUS_OK;
    end
    verdict.image_bytes = size[fwiv_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
      crc_value  <= fwiv_pkg::CRC_INIT;
      tail_bytes <= '0;
    end else if (step) begin
      if (beat.last) begin
        byte_total <= '0;
        crc_value  <= fwiv_pkg::CRC_INIT;
        tail_bytes <= '0;
      end else begin
        byte_total <= byte_total_next;
        crc_value  <= crc_value_next;
        tail_bytes <= tail_bytes_next;
      end
    end
  end

endmodule

FILE: src/firmware_image_validator.sv
// A final beat is held in the input register, then its verdict in the verdict register.
// Throughput: one byte beat per cycle, except where a stalled verdict holds back
// the next final beat and the beats behind it; the byte-wide CRC step, count
// and footer update sit between the input register and the verdict register.
// Reset (rst, synchronous): empties both registers, restarts the image
// state (count 0, CRC 0xFFFF, footer 0) and loads the default config.
module firmware_image_validator #(
  parameter int COUNT_WIDTH = fwiv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  fwiv_byte_if.sink                         image,
  fwiv_verdict_if.source                    verdict,
  input  logic                              cfg_we,
  input  logic [fwiv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fwiv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers; writes to an unused index are dropped.
  fwiv_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_size  <= fwiv_pkg::MIN_SIZE_RST;
      cfg.max_size  <= fwiv_pkg::MAX_SIZE_RST;
      cfg.signature <= fwiv_pkg::SIGNATURE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fwiv_pkg::REG_MIN_SIZE:  cfg.min_size  <= cfg_data[fwiv_pkg::SIZE_W-1:0];
        fwiv_pkg::REG_MAX_SIZE:  cfg.max_size  <= cfg_data[fwiv_pkg::SIZE_W-1:0];
        fwiv_pkg::REG_SIGNATURE: cfg.signature <= cfg_data[fwiv_pkg::SIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: holds one accepted beat until it is processed.
  logic               s1_valid;
  fwiv_pkg::beat_t    s1_beat;
  logic               s1_adv;

  // Output register: the pending verdict beat.
  logic               out_valid;
  fwiv_pkg::verdict_t out_data;
  fwiv_pkg::verdict_t verdict_next;

  // A data beat never needs the output slot; a final beat needs it free
  // or being emptied this cycle.
  assign s1_adv      = s1_valid && (!s1_beat.last || !out_valid || verdict.ready);
  assign image.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (image.ready) begin
      s1_valid <= image.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (image.ready) begin
      s1_beat.data <= image.data_byte;
      s1_beat.last <= image.final_byte;
    end
  end

  fwiv_image_state #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_state (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .beat   (s1_beat),
    .cfg    (cfg),
    .verdict(verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_beat.last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_beat.last) begin
      out_data <= verdict_next;
    end
  end

  assign verdict.valid       = out_valid;
  assign verdict.status      = out_data.status;
  assign verdict.image_bytes = out_data.image_bytes;

  // A beat that cannot move stays in the input register unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_beat))
    else $error("input register lost or changed a stalled beat");

  // Data beats never touch the verdict slot.
  a_data_no_verdict: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1_beat.last |=> out_valid == $past(out_valid && !verdict.ready))
    else $error("data beat disturbed the verdict register");

  // A final beat is only taken when the verdict slot can receive it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_beat.last |-> !out_valid || verdict.ready)
    else $error("pending verdict overwritten");

  // Only the three defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == fwiv_pkg::STATUS_OK ||
                  out_data.status == fwiv_pkg::STATUS_BAD_FILE ||
                  out_data.status == fwiv_pkg::STATUS_BAD_CRC)
    else $error("undefined status code");

endmodule
